// ===== sv/etof_pkg.sv =====
// Shared constants, types and helpers for the event time-of-flight histogrammer.
// No dependencies; the design files refer to it by scoped names, the bench imports it.
package etof_pkg;

    // Store geometry defaults
    localparam int MAX_X_DEF     = 64;
    localparam int MAX_Y_DEF     = 64;
    localparam int TIME_BINS_DEF = 512;

    // Raw time range covered by the bins in use
    localparam int TIME_RANGE = 4096;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 16;
    localparam int TIME_W   = 16;
    localparam int BIDX_W   = 9;
    localparam int CNT_W    = 32;
    localparam int BS_W     = 13;
    localparam int SLICE_W  = 12;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 8;
    localparam int ROUND_HALF = 128;   // 0.5 in 8.8

    // Stream payload widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_BIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;

    localparam logic [BS_W-1:0]    BIN_SIZE_RST  = 13'd10;
    localparam logic [SLICE_W-1:0] SLICE_BIN_RST = 12'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd256;

    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_EVENT = 2'd0;
    localparam t_func FUNC_READ  = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;
    localparam t_func FUNC_NOP   = 2'd3;

    typedef struct packed {
        logic             oor;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] slice;
        logic [CNT_W-1:0] bcount;
    } t_result;

    function automatic int addr_w(input longint unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== sv/etof_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Uses etof_pkg for the address width helper.
module etof_ram #(
    parameter int WIDTH = 32,
    parameter longint unsigned DEPTH = 512,
    localparam int AW = etof_pkg::addr_w(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/etof_div.sv =====
// Radix-2 restoring divider for time / bin_size, one quotient bit per cycle.
// Uses etof_pkg for the dividend and divisor widths.
module etof_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [etof_pkg::TIME_W-1:0] i_dividend,
    input  logic [etof_pkg::BS_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [etof_pkg::TIME_W-1:0] o_quotient
);

    localparam int NW = etof_pkg::TIME_W;
    localparam int DW = etof_pkg::BS_W;
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [DW:0]   w_rem_sh;
    logic          w_fit;
    logic [DW:0]   w_diff;

    assign w_rem_sh = {r_rem, r_quo[NW-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_div});
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // shift the next dividend bit out of the top, shift the quotient bit into the bottom
            r_rem <= w_fit ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_fit};
        end
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== sv/etof_gain.sv =====
// Gain stage: round(gain * count) in unsigned 8.8, saturated to 32 bits, registered.
// Uses etof_pkg for widths and the rounding constant.
module etof_gain (
    input  logic                        i_clk,
    input  logic [etof_pkg::GAIN_W-1:0] i_gain,
    input  logic [etof_pkg::CNT_W-1:0]  i_count,
    output logic [etof_pkg::CNT_W-1:0]  o_value
);

    localparam int PW = etof_pkg::GAIN_W + etof_pkg::CNT_W;
    localparam int SW = PW + 1;
    localparam int HW = SW - etof_pkg::FRAC_W;

    logic [PW-1:0] w_prod;
    logic [SW-1:0] w_sum;
    logic [HW-1:0] w_shr;
    logic          w_sat;

    assign w_prod = PW'(i_gain) * PW'(i_count);
    assign w_sum  = SW'(w_prod) + SW'(etof_pkg::ROUND_HALF);
    assign w_shr  = w_sum[SW-1:etof_pkg::FRAC_W];
    assign w_sat  = |w_shr[HW-1:etof_pkg::CNT_W];

    always_ff @(posedge i_clk) begin
        o_value <= w_sat ? '1 : w_shr[etof_pkg::CNT_W-1:0];
    end

endmodule

// ===== sv/event_tof_histogrammer.sv =====
// Event time-of-flight histogrammer: events, reads and clears go through one sequencer
// that reads, modifies and writes back three counter RAMs (time histogram, pixel-by-bin
// cube, pixel totals). An event runs through the prepare, base, divide, check, read-request
// and update states, going from check straight to the output when it falls outside the
// stores; in the divide state the one-bit-per-cycle divider turns arrival time into a bin.
// A read runs through the prepare, base, check, read-request, gain and result states, for
// the registered RAM read data and the registered gain multipliers. A clear, and likewise
// the start-up after reset, sweeps all three RAMs in parallel one entry per cycle; no item
// is accepted meanwhile, configuration writes are taken always. Items are handled one at a
// time; the next is taken as soon as a result sits in the output register, even if it has
// not yet been collected. Depends on etof_pkg, etof_ram, etof_div and etof_gain.
module event_tof_histogrammer #(
    parameter int MAX_X     = etof_pkg::MAX_X_DEF,
    parameter int MAX_Y     = etof_pkg::MAX_Y_DEF,
    parameter int TIME_BINS = etof_pkg::TIME_BINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [etof_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [etof_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x[15:0], pos_y[31:16], arrival_time[47:32], bin_index[56:48], zeros above
    input  logic [etof_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [etof_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // total_value[31:0], slice_value[63:32], bin_count[95:64]
    output logic [etof_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // out_of_range[0]
    output logic [etof_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    localparam int PIXELS = MAX_X * MAX_Y;
    localparam longint unsigned CUBE_DEPTH = longint'(PIXELS) * longint'(TIME_BINS);
    localparam int HAW = etof_pkg::addr_w(TIME_BINS);
    localparam int PAW = etof_pkg::addr_w(PIXELS);
    localparam int CAW = etof_pkg::addr_w(CUBE_DEPTH);
    localparam int CNT_W = etof_pkg::CNT_W;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_RDREQ = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_GAIN  = 4'd8;
    localparam logic [3:0] S_RES   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // configuration
    logic [etof_pkg::BS_W-1:0]    r_cfg_bs;
    logic [etof_pkg::SLICE_W-1:0] r_cfg_slice;
    logic [etof_pkg::GAIN_W-1:0]  r_cfg_gain;

    // current item
    etof_pkg::t_func                     r_func;
    logic signed [etof_pkg::POS_W-1:0]   r_x;
    logic signed [etof_pkg::POS_W-1:0]   r_y;
    logic signed [etof_pkg::TIME_W-1:0]  r_t;
    logic [etof_pkg::BIDX_W-1:0]         r_bidx;

    logic           r_pix_ok;
    logic [PAW-1:0] r_pix;
    logic [CAW-1:0] r_base;
    logic [CAW-1:0] r_cube_addr;
    logic [HAW-1:0] r_hist_addr;
    logic           r_bin_ok;
    logic           r_slice_ok;
    etof_pkg::t_result r_res;

    // clearing sweep
    logic           r_clr_resp;
    logic [HAW-1:0] r_clr_bin;
    logic [PAW-1:0] r_clr_pix;
    logic [CAW-1:0] r_clr_lin;
    logic           w_clr_last;

    // output register
    logic                              r_m_valid;
    logic [etof_pkg::M_TDATA_W-1:0]    r_m_data;
    logic [etof_pkg::M_TUSER_W-1:0]    r_m_user;

    logic w_in_acc;
    logic w_out_free;
    logic [etof_pkg::BS_W-1:0]   w_bs;
    logic [etof_pkg::TIME_W-1:0] w_mag;
    logic                        w_div_done;
    logic [etof_pkg::TIME_W-1:0] w_q;
    logic                        w_x_ok;
    logic                        w_y_ok;
    logic                        w_t_ok;
    logic                        w_ev_ok;

    logic             w_wr_clr;
    logic             w_we;
    logic [CNT_W-1:0] w_hist_rd;
    logic [CNT_W-1:0] w_cube_rd;
    logic [CNT_W-1:0] w_tot_rd;
    logic [CNT_W-1:0] w_g_total;
    logic [CNT_W-1:0] w_g_slice;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign w_bs  = (r_cfg_bs == '0) ? etof_pkg::BS_W'(1) : r_cfg_bs;
    assign w_mag = r_t[etof_pkg::TIME_W-1] ? etof_pkg::TIME_W'(-r_t) : r_t;

    assign w_x_ok = !r_x[etof_pkg::POS_W-1] && (32'(r_x[etof_pkg::POS_W-2:0]) < 32'(MAX_X));
    assign w_y_ok = !r_y[etof_pkg::POS_W-1] && (32'(r_y[etof_pkg::POS_W-2:0]) < 32'(MAX_Y));

    // bin q is in use when q < TIME_BINS and q * bin_size < 4096
    assign w_t_ok = (!r_t[etof_pkg::TIME_W-1] || (w_q == '0))
                    && (32'(w_q) < 32'(TIME_BINS))
                    && ((29'(w_q) * 29'(w_bs)) < 29'(etof_pkg::TIME_RANGE));
    assign w_ev_ok = r_pix_ok && w_t_ok;

    assign w_clr_last = (r_clr_lin == CAW'(CUBE_DEPTH - 1));

    etof_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_PREP) && (r_func == etof_pkg::FUNC_EVENT)),
        .i_dividend (w_mag),
        .i_divisor  (w_bs),
        .o_done     (w_div_done),
        .o_quotient (w_q)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (w_clr_last) begin
                    n_state = r_clr_resp ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    case (s_axis_tuser)
                        etof_pkg::FUNC_EVENT: n_state = S_PREP;
                        etof_pkg::FUNC_READ:  n_state = S_PREP;
                        etof_pkg::FUNC_CLEAR: n_state = S_CLR;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_PREP: n_state = S_BASE;
            S_BASE: n_state = (r_func == etof_pkg::FUNC_EVENT) ? S_DIV : S_CHK;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_func == etof_pkg::FUNC_EVENT) begin
                    n_state = w_ev_ok ? S_RDREQ : S_OUT;
                end else begin
                    n_state = S_RDREQ;
                end
            end
            S_RDREQ: n_state = (r_func == etof_pkg::FUNC_EVENT) ? S_UPD : S_GAIN;
            S_UPD:   n_state = S_OUT;
            S_GAIN:  n_state = S_RES;
            S_RES:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_resp  <= 1'b0;
            r_clr_bin   <= '0;
            r_clr_pix   <= '0;
            r_clr_lin   <= '0;
            r_cfg_bs    <= etof_pkg::BIN_SIZE_RST;
            r_cfg_slice <= etof_pkg::SLICE_BIN_RST;
            r_cfg_gain  <= etof_pkg::GAIN_RST;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    etof_pkg::REG_BIN_SIZE:  r_cfg_bs    <= i_cfg_data[etof_pkg::BS_W-1:0];
                    etof_pkg::REG_SLICE_BIN: r_cfg_slice <= i_cfg_data[etof_pkg::SLICE_W-1:0];
                    etof_pkg::REG_GAIN:      r_cfg_gain  <= i_cfg_data[etof_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_clr_resp <= (s_axis_tuser == etof_pkg::FUNC_CLEAR);
            end

            // sweep bin inside pixel, matching the pixel-major cube layout
            if (r_state == S_CLR) begin
                if (w_clr_last) begin
                    r_clr_bin <= '0;
                    r_clr_pix <= '0;
                    r_clr_lin <= '0;
                end else begin
                    r_clr_lin <= r_clr_lin + 1'b1;
                    if (r_clr_bin == HAW'(TIME_BINS - 1)) begin
                        r_clr_bin <= '0;
                        r_clr_pix <= r_clr_pix + 1'b1;
                    end else begin
                        r_clr_bin <= r_clr_bin + 1'b1;
                    end
                end
            end

            if ((r_state == S_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_func <= s_axis_tuser;
                    r_x    <= s_axis_tdata[15:0];
                    r_y    <= s_axis_tdata[31:16];
                    r_t    <= s_axis_tdata[47:32];
                    r_bidx <= s_axis_tdata[56:48];
                    r_res  <= '0;
                end
            end
            S_PREP: begin
                r_pix_ok <= w_x_ok && w_y_ok;
                r_pix    <= PAW'(32'(r_y[etof_pkg::POS_W-2:0]) * 32'(MAX_X)
                                 + 32'(r_x[etof_pkg::POS_W-2:0]));
            end
            S_BASE: begin
                r_base      <= CAW'(r_pix) * CAW'(TIME_BINS);
                r_hist_addr <= HAW'(r_bidx);
                r_bin_ok    <= (32'(r_bidx) < 32'(TIME_BINS))
                               && ((22'(r_bidx) * 22'(w_bs)) < 22'(etof_pkg::TIME_RANGE));
                r_slice_ok  <= (32'(r_cfg_slice) < 32'(TIME_BINS))
                               && ((25'(r_cfg_slice) * 25'(w_bs)) < 25'(etof_pkg::TIME_RANGE));
            end
            S_CHK: begin
                if (r_func == etof_pkg::FUNC_EVENT) begin
                    r_cube_addr <= r_base + CAW'(w_q);
                    r_hist_addr <= HAW'(w_q);
                    r_res.oor   <= !w_ev_ok;
                end else begin
                    r_cube_addr <= r_base + CAW'(r_cfg_slice);
                end
            end
            S_GAIN: begin
                r_res.bcount <= r_bin_ok ? w_hist_rd : '0;
                r_res.oor    <= !r_pix_ok || !r_bin_ok;
            end
            S_RES: begin
                r_res.total <= r_pix_ok ? w_g_total : '0;
                r_res.slice <= (r_pix_ok && r_slice_ok) ? w_g_slice : '0;
            end
            default: ;
        endcase

        if ((r_state == S_OUT) && w_out_free) begin
            r_m_data <= {r_res.bcount, r_res.slice, r_res.total};
            r_m_user <= r_res.oor;
        end
    end

    // ---------------------------------------------------------------- counter stores
    assign w_wr_clr = (r_state == S_CLR);
    assign w_we     = w_wr_clr || (r_state == S_UPD);

    etof_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TIME_BINS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_clr ? r_clr_bin : r_hist_addr),
        .i_wdata (w_wr_clr ? '0 : w_hist_rd + 1'b1),
        .i_raddr (r_hist_addr),
        .o_rdata (w_hist_rd)
    );

    etof_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CUBE_DEPTH)
    ) u_cube_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_clr ? r_clr_lin : r_cube_addr),
        .i_wdata (w_wr_clr ? '0 : w_cube_rd + 1'b1),
        .i_raddr (r_cube_addr),
        .o_rdata (w_cube_rd)
    );

    etof_ram #(
        .WIDTH (CNT_W),
        .DEPTH (PIXELS)
    ) u_total_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_clr ? r_clr_pix : r_pix),
        .i_wdata (w_wr_clr ? '0 : w_tot_rd + 1'b1),
        .i_raddr (r_pix),
        .o_rdata (w_tot_rd)
    );

    etof_gain u_gain_total (
        .i_clk   (i_clk),
        .i_gain  (r_cfg_gain),
        .i_count (w_tot_rd),
        .o_value (w_g_total)
    );

    etof_gain u_gain_slice (
        .i_clk   (i_clk),
        .i_gain  (r_cfg_gain),
        .i_count (w_cube_rd),
        .o_value (w_g_slice)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== test/event_tof_histogrammer_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for event_tof_histogrammer: a behavioral copy of the three counter
// stores predicts every result, while both stream sides idle and stall at random.
// Depends on etof_pkg and the RTL of the block; clears sweep the full stores, so few are sent.
module event_tof_histogrammer_test;
    import etof_pkg::*;

    localparam int NX           = MAX_X_DEF;
    localparam int NY           = MAX_Y_DEF;
    localparam int NBINS_MAX    = TIME_BINS_DEF;
    localparam int NPIX         = NX * NY;
    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASES       = 7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    event_tof_histogrammer #(
        .MAX_X     (NX),
        .MAX_Y     (NY),
        .TIME_BINS (NBINS_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predicted stores and settings
    logic [CNT_W-1:0]   tof_hist    [NBINS_MAX];
    logic [CNT_W-1:0]   pix_bin_cnt [NPIX * NBINS_MAX];
    logic [CNT_W-1:0]   pix_total   [NPIX];
    logic [BS_W-1:0]    cfg_bin_size  = BIN_SIZE_RST;
    logic [SLICE_W-1:0] cfg_slice_bin = SLICE_BIN_RST;
    logic [GAIN_W-1:0]  cfg_gain      = GAIN_RST;
    t_result            due_results[$];

    // stream pacing knobs
    int tx_max_gap     = 3;
    int tx_max_burst   = 4;
    int tx_burst_left  = 0;
    int rx_max_stall   = 3;
    int rx_hold_cycles = 0;
    int rx_run_left    = 0;
    bit rx_stalling    = 1'b0;

    int n_fail    = 0;
    int n_events  = 0;
    int n_binned  = 0;
    int n_reads   = 0;
    int n_clears  = 0;
    int n_checked = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned eff_bin_size();
        return (cfg_bin_size == 0) ? 1 : int'(cfg_bin_size);
    endfunction

    function automatic int unsigned bins_used();
        int unsigned n;
        n = (TIME_RANGE + eff_bin_size() - 1) / eff_bin_size();
        return (n > NBINS_MAX) ? NBINS_MAX : n;
    endfunction

    function automatic logic [CNT_W-1:0] apply_gain(logic [CNT_W-1:0] count);
        logic [63:0] p;
        p = (64'(cfg_gain) * 64'(count) + ROUND_HALF) >> FRAC_W;
        return (p > 64'hFFFF_FFFF) ? '1 : p[CNT_W-1:0];
    endfunction

    function automatic bit pixel_inside(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
        return x >= 0 && x < NX && y >= 0 && y < NY;
    endfunction

    function automatic void clear_stores();
        foreach (tof_hist[i]) tof_hist[i] = '0;
        foreach (pix_bin_cnt[i]) pix_bin_cnt[i] = '0;
        foreach (pix_total[i]) pix_total[i] = '0;
    endfunction

    // Update the stores for one item and return the result it must produce.
    function automatic t_result tally_item(t_func f, logic signed [POS_W-1:0] x,
                                           logic signed [POS_W-1:0] y,
                                           logic signed [TIME_W-1:0] t,
                                           logic [BIDX_W-1:0] bidx);
        t_result     r;
        int unsigned bs, nb, mag, q, pix;
        bit          tok;
        r  = '0;
        bs = eff_bin_size();
        nb = bins_used();
        case (f)
            FUNC_EVENT: begin
                mag = (t < 0) ? -int'(t) : int'(t);
                q   = mag / bs;
                // truncation toward zero: small negative times land in bin 0
                tok = (t >= 0 || q == 0) && q < nb;
                if (pixel_inside(x, y) && tok) begin
                    pix = int'(y) * NX + int'(x);
                    tof_hist[q] = tof_hist[q] + 1;
                    pix_bin_cnt[pix * NBINS_MAX + q] = pix_bin_cnt[pix * NBINS_MAX + q] + 1;
                    pix_total[pix] = pix_total[pix] + 1;
                    n_binned++;
                end else begin
                    r.oor = 1'b1;
                end
            end
            FUNC_READ: begin
                if (pixel_inside(x, y)) begin
                    pix     = int'(y) * NX + int'(x);
                    r.total = apply_gain(pix_total[pix]);
                    if (cfg_slice_bin < nb)
                        r.slice = apply_gain(pix_bin_cnt[pix * NBINS_MAX + cfg_slice_bin]);
                end else begin
                    r.oor = 1'b1;
                end
                if (bidx < nb)
                    r.bcount = tof_hist[bidx];
                else
                    r.oor = 1'b1;
            end
            FUNC_CLEAR: clear_stores();
            default: ;
        endcase
        return r;
    endfunction

    // Offer one item, hold it until accepted, then maybe end the burst with a gap.
    task automatic send_item(t_func f, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [TIME_W-1:0] t, logic [BIDX_W-1:0] bidx);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {7'b0, bidx, t, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        due_results.push_back(tally_item(f, x, y, t, bidx));
        case (f)
            FUNC_EVENT: n_events++;
            FUNC_READ:  n_reads++;
            FUNC_CLEAR: n_clears++;
            default: ;
        endcase
        if (tx_burst_left > 0)
            tx_burst_left--;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, tx_max_burst);
            if (tx_max_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_max_gap)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BIN_SIZE:  cfg_bin_size  = data[BS_W-1:0];
            REG_SLICE_BIN: cfg_slice_bin = data[SLICE_W-1:0];
            REG_GAIN:      cfg_gain      = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] bs, logic [CFG_DATA_W-1:0] slice,
                             logic [CFG_DATA_W-1:0] gain, bit poke_spare);
        if (poke_spare)
            write_reg(REG_SPARE, '1);
        write_reg(REG_BIN_SIZE, bs);
        write_reg(REG_SLICE_BIN, slice);
        write_reg(REG_GAIN, gain);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly in-range events and reads against the current settings, plus strays.
    task automatic send_random_item();
        int unsigned      sel, bs, nb, lim;
        logic [POS_W-1:0] x, y;
        logic [TIME_W-1:0] t;
        logic [BIDX_W-1:0] bidx;
        sel  = $urandom_range(0, 99);
        bs   = eff_bin_size();
        nb   = bins_used();
        lim  = bs * nb;
        x    = $urandom_range(0, NX - 1);
        y    = $urandom_range(0, NY - 1);
        t    = $urandom;
        bidx = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: x = $urandom;
                1: y = $urandom;
                2: x = $urandom_range(0, 1) ? 16'hFFFF : 16'(NX);
                default: y = $urandom_range(0, 1) ? 16'hFFFF : 16'(NY);
            endcase
        end
        if (sel < 55) begin
            case ($urandom_range(0, 19))
                0, 1: t = $urandom_range(lim, lim + bs);
                2, 3: t = 16'(-int'($urandom_range(0, bs)));
                4: ;
                default: t = $urandom_range(0, lim - 1);
            endcase
            send_item(FUNC_EVENT, x, y, t, bidx);
        end else if (sel < 93) begin
            if ($urandom_range(0, 7) != 0)
                bidx = $urandom_range(0, nb - 1);
            send_item(FUNC_READ, x, y, t, bidx);
        end else begin
            send_item(FUNC_NOP, x, y, t, bidx);
        end
    endtask

    // Edges of every field at the reset settings (10 units per bin, 410 bins in use).
    task automatic test_directed();
        send_item(FUNC_EVENT, 0, 0, 0, 0);
        send_item(FUNC_EVENT, NX - 1, NY - 1, 4099, 9'h1FF);
        send_item(FUNC_EVENT, NX - 1, NY - 1, 4100, 0);
        send_item(FUNC_EVENT, 1, 1, 16'(-9), 0);
        send_item(FUNC_EVENT, 1, 1, 16'(-10), 0);
        send_item(FUNC_EVENT, 16'hFFFF, 0, 5, 0);
        send_item(FUNC_EVENT, NX, 0, 5, 0);
        send_item(FUNC_EVENT, 0, NY, 5, 0);
        send_item(FUNC_EVENT, 16'h7FFF, 16'h8000, 5, 0);
        send_item(FUNC_EVENT, 2, 1, 16'h7FFF, 0);
        send_item(FUNC_EVENT, 2, 1, 16'h8000, 0);
        send_item(FUNC_EVENT, 0, 0, 9, 0);
        send_item(FUNC_READ, 0, 0, 0, 0);
        send_item(FUNC_READ, NX - 1, NY - 1, 0, 409);
        send_item(FUNC_READ, NX - 1, NY - 1, 16'hFFFF, 410);
        send_item(FUNC_READ, 16'hFFFF, 2, 0, 0);
        send_item(FUNC_READ, 16'h7FFF, 16'h8000, 16'hAAAA, 9'h1FF);
        send_item(FUNC_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF);
        send_item(FUNC_CLEAR, 0, 0, 0, 0);
        send_item(FUNC_READ, 0, 0, 0, 0);
        send_item(FUNC_READ, NX - 1, NY - 1, 0, 409);
    endtask

    // Rounding and extremes of the gain, and a slice bin beyond the bins in use.
    task automatic test_gain_and_slice();
        logic [GAIN_W-1:0] gains[5];
        gains = '{16'd0, 16'd128, 16'd383, 16'hFFFF, 16'd256};
        send_item(FUNC_EVENT, 3, 2, 630, 0);
        send_item(FUNC_EVENT, 3, 2, 635, 0);
        send_item(FUNC_EVENT, 3, 2, 100, 0);
        foreach (gains[i]) begin
            wait_drained();
            configure(10, 63, gains[i], 1'b0);
            send_item(FUNC_READ, 3, 2, 0, 63);
        end
        wait_drained();
        configure(10, 4095, 256, 1'b0);
        send_item(FUNC_READ, 3, 2, 0, 10);
    endtask

    // Long output stall with the input kept busy, then a full pause of the input.
    task automatic test_backpressure();
        wait_drained();
        tx_max_gap     = 0;
        rx_max_stall   = 0;
        rx_hold_cycles = 400;
        repeat (30) send_random_item();
        wait_drained();
        tx_max_gap   = 4;
        tx_max_burst = 6;
        rx_max_stall = 5;
        repeat (20) send_random_item();
        wait_drained();
        repeat (20) send_random_item();
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] bs_set[PHASES];
        logic [CFG_DATA_W-1:0] slice_set[PHASES];
        logic [CFG_DATA_W-1:0] gain_set[PHASES];
        bs_set    = '{16'd8, 16'd4096, 16'd0, 16'd8191, 16'd100, 16'hF020, 16'd64};
        slice_set = '{16'd63, 16'd0, 16'd5, 16'd4095, 16'd40, 16'hF03F, 16'd17};
        gain_set  = '{16'hFFFF, 16'd0, 16'd128, 16'd384, 16'd1, 16'd256, 16'd300};
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            configure(bs_set[ph], slice_set[ph], gain_set[ph], ph == 3);
            if (ph % 3 == 0) begin
                tx_max_gap   = 0;
                rx_max_stall = 0;
            end else begin
                tx_max_gap   = $urandom_range(1, 6);
                rx_max_stall = $urandom_range(1, 8);
            end
            tx_max_burst = $urandom_range(1, 16);
            // a clear sweeps the whole cube, so start only a few phases from empty stores
            if (ph % 3 == 1)
                send_item(FUNC_CLEAR, 0, 0, 0, 0);
            repeat (RANDOM_ITEMS / PHASES) send_random_item();
        end
    endtask

    // Receiver: random ready/stall runs, or a forced hold when one is requested.
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                rx_stalling = !rx_stalling && rx_max_stall > 0;
                rx_run_left = rx_stalling ? $urandom_range(1, rx_max_stall)
                                          : $urandom_range(1, 12);
            end
            rx_run_left--;
            m_axis_tready <= !rx_stalling;
        end
    end

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $error("result with nothing pending: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                n_checked++;
                check_field("out_of_range", CNT_W'(want.oor), CNT_W'(m_axis_tuser[0]));
                check_field("total_value", want.total, m_axis_tdata[31:0]);
                check_field("slice_value", want.slice, m_axis_tdata[63:32]);
                check_field("bin_count", want.bcount, m_axis_tdata[95:64]);
            end
        end
    end

    initial begin
        clear_stores();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_gain_and_slice();
        test_backpressure();
        test_random_phases();
        wait_drained();
        // catch any stray transaction after the last expected one
        repeat (60) @(posedge i_clk);
        $display("covered %0d events (%0d binned), %0d reads, %0d clears over %0d settings",
                 n_events, n_binned, n_reads, n_clears, PHASES + 7);
        $display("%0d results compared, %0d mismatches", n_checked, n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== event_tof_histogrammer.f =====
sv/etof_pkg.sv
sv/etof_ram.sv
sv/etof_div.sv
sv/etof_gain.sv
sv/event_tof_histogrammer.sv
test/event_tof_histogrammer_test.sv
